### rtl/tsd_pkg.sv
// tsd_pkg: shared types, codes, widths and the hex segment decode for the
// text to seven-segment display core. No dependencies.
`timescale 1ns / 1ps

package tsd_pkg;

    // default geometry
    localparam int DIGITS_DEFAULT     = 16;
    localparam int ROW_LENGTH_DEFAULT = 8;

    // payload widths of the channels
    localparam int CMD_W        = 2;
    localparam int BYTE_W       = 8;
    localparam int INDEX_OUT_W  = 4;
    localparam int CURSOR_OUT_W = 5;
    localparam int COLUMN_OUT_W = 3;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_POINT_MASK   = 1'b0,
        REG_DASH_PATTERN = 1'b1
    } cfg_reg_t;

    localparam logic [BYTE_W-1:0] POINT_MASK_RESET   = 8'h10;
    localparam logic [BYTE_W-1:0] DASH_PATTERN_RESET = 8'h40;

    typedef enum logic [CMD_W-1:0] {
        CMD_DATA  = 2'd0,
        CMD_SETUP = 2'd1,
        CMD_SCAN  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_WRITE,
        OP_POINT,
        OP_SCAN
    } op_kind_t;

    // work handed from the decode stage to the store/result stage
    typedef struct packed {
        op_kind_t          kind;
        logic [BYTE_W-1:0] pattern;
        logic              lo_ok;
        logic              hi_ok;
    } op_t;

    localparam logic [BYTE_W-1:0] CHAR_NUL     = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_DASH    = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_PERIOD  = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_F = 8'h46;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_F = 8'h66;
    localparam logic [BYTE_W-1:0] HEX_TEN      = 8'd10;

    localparam logic [BYTE_W-1:0] HEX_SEGMENTS [16] = '{
        8'hAF, 8'h21, 8'hCD, 8'h6D, 8'h63, 8'h6E, 8'hEE, 8'h25,
        8'hEF, 8'h6F, 8'hE7, 8'hEA, 8'hC8, 8'hE9, 8'hCE, 8'hC6
    };

    // segment pattern for one character; anything unknown is blank
    function automatic logic [BYTE_W-1:0] seg_decode(
        input logic [BYTE_W-1:0] ch,
        input logic [BYTE_W-1:0] dash
    );
        logic [BYTE_W-1:0] seg;
        seg = '0;
        if (ch == CHAR_DASH)
            seg = dash;
        else if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
            seg = HEX_SEGMENTS[4'(ch - CHAR_ZERO)];
        else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_F)
            seg = HEX_SEGMENTS[4'(ch - CHAR_UPPER_A + HEX_TEN)];
        else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_F)
            seg = HEX_SEGMENTS[4'(ch - CHAR_LOWER_A + HEX_TEN)];
        return seg;
    endfunction

endpackage

### rtl/tsd_channels.sv
// tsd_channels: valid/ready channel interfaces for request and result items.
// Depends on tsd_pkg for payload widths.
`timescale 1ns / 1ps

interface tsd_req_if;
    import tsd_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [BYTE_W-1:0]   data_byte;
    logic                packet_end;

    modport source (output valid, output cmd, output data_byte, output packet_end,
                    input ready);
    modport sink   (input valid, input cmd, input data_byte, input packet_end,
                    output ready);
endinterface

interface tsd_rsp_if;
    import tsd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    wrote_digit;
    logic [INDEX_OUT_W-1:0]  digit_index;
    logic [BYTE_W-1:0]       digit_pattern;
    logic [CURSOR_OUT_W-1:0] cursor_now;
    logic [COLUMN_OUT_W-1:0] scan_column;
    logic [BYTE_W-1:0]       upper_row_pattern;
    logic [BYTE_W-1:0]       lower_row_pattern;

    modport source (output valid, output wrote_digit, output digit_index,
                    output digit_pattern, output cursor_now, output scan_column,
                    output upper_row_pattern, output lower_row_pattern,
                    input ready);
    modport sink   (input valid, input wrote_digit, input digit_index,
                    input digit_pattern, input cursor_now, input scan_column,
                    input upper_row_pattern, input lower_row_pattern,
                    output ready);
endinterface

### rtl/tsd_ctrl.sv
// tsd_ctrl: input register, cursor / row / scan / skip state and character
// decode. Depends on tsd_pkg and tsd_req_if.
`timescale 1ns / 1ps

module tsd_ctrl #(
    parameter int DIGITS     = tsd_pkg::DIGITS_DEFAULT,
    parameter int ROW_LENGTH = tsd_pkg::ROW_LENGTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    tsd_req_if.sink                             req,
    input  logic                                s2_adv,
    input  logic [tsd_pkg::BYTE_W-1:0]          dash_pattern,
    output logic                                s1_vld,
    output tsd_pkg::op_t                        op,
    output logic [$clog2(DIGITS)-1:0]           addr_a,
    output logic [$clog2(DIGITS)-1:0]           addr_b,
    output logic [tsd_pkg::CURSOR_OUT_W-1:0]    cursor_now,
    output logic [tsd_pkg::COLUMN_OUT_W-1:0]    scan_col
);
    import tsd_pkg::*;

    localparam int AW = $clog2(DIGITS);
    localparam int CW = $clog2(DIGITS + 1);
    localparam int RW = (ROW_LENGTH > 1) ? $clog2(ROW_LENGTH) : 1;
    localparam int WW = $clog2(DIGITS + 2 * ROW_LENGTH + 1);

    logic              s1_vld_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [BYTE_W-1:0] char_reg;
    logic              last_reg;

    logic [CW-1:0] cursor_reg, cursor_next;
    logic [RW-1:0] col_reg, col_next;
    logic [RW-1:0] scan_reg, scan_next;
    logic          skip_reg, skip_next;

    logic          s1_adv;
    logic          step;
    logic [WW-1:0] row_end;
    logic [WW-1:0] lo_pos;
    logic [WW-1:0] hi_pos;

    assign s1_adv    = !s1_vld_reg || s2_adv;
    assign step      = s1_vld_reg && s2_adv;
    assign req.ready = s1_adv;
    assign s1_vld    = s1_vld_reg;

    always_comb
    begin
        cursor_next = cursor_reg;
        col_next    = col_reg;
        scan_next   = scan_reg;
        skip_next   = skip_reg;
        op          = '{kind: OP_NONE, pattern: '0, lo_ok: 1'b0, hi_ok: 1'b0};
        addr_a      = '0;
        addr_b      = '0;
        scan_col    = '0;
        row_end     = WW'(cursor_reg) + WW'(ROW_LENGTH) - WW'(col_reg);
        lo_pos      = WW'(scan_reg);
        hi_pos      = WW'(scan_reg) + WW'(ROW_LENGTH);
        unique case (cmd_reg)
            CMD_DATA:
            begin
                priority if (skip_reg)
                begin
                    if (last_reg)
                        skip_next = 1'b0;
                end
                else if (char_reg == CHAR_NUL)
                begin
                    cursor_next = '0;
                    col_next    = '0;
                    skip_next   = !last_reg;
                end
                else if (char_reg == CHAR_NEWLINE)
                begin
                    // already at a row start or at the end: nothing moves
                    if (cursor_reg != CW'(DIGITS) && col_reg != '0)
                    begin
                        cursor_next = (row_end > WW'(DIGITS)) ? CW'(DIGITS) : CW'(row_end);
                        col_next    = '0;
                    end
                end
                else if (char_reg == CHAR_PERIOD)
                begin
                    if (cursor_reg != '0)
                    begin
                        op.kind = OP_POINT;
                        addr_a  = AW'(cursor_reg - 1'b1);
                    end
                end
                else if (cursor_reg < CW'(DIGITS))
                begin
                    op.kind     = OP_WRITE;
                    op.pattern  = seg_decode(char_reg, dash_pattern);
                    addr_a      = AW'(cursor_reg);
                    cursor_next = cursor_reg + 1'b1;
                    col_next    = (col_reg == RW'(ROW_LENGTH - 1)) ? '0 : col_reg + 1'b1;
                end
            end
            CMD_SETUP:
            begin
                if (char_reg == CHAR_NUL)
                begin
                    cursor_next = '0;
                    col_next    = '0;
                end
                skip_next = 1'b0;
            end
            CMD_SCAN:
            begin
                op.kind   = OP_SCAN;
                op.lo_ok  = lo_pos < WW'(DIGITS);
                op.hi_ok  = hi_pos < WW'(DIGITS);
                addr_a    = AW'(lo_pos);
                addr_b    = AW'(hi_pos);
                scan_col  = COLUMN_OUT_W'(scan_reg);
                scan_next = (scan_reg == RW'(ROW_LENGTH - 1)) ? '0 : scan_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
        cursor_now = CURSOR_OUT_W'(cursor_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            cursor_reg <= '0;
            col_reg    <= '0;
            scan_reg   <= '0;
            skip_reg   <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_vld_reg <= req.valid;
            if (step)
            begin
                cursor_reg <= cursor_next;
                col_reg    <= col_next;
                scan_reg   <= scan_next;
                skip_reg   <= skip_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && req.valid)
        begin
            cmd_reg  <= req.cmd;
            char_reg <= req.data_byte;
            last_reg <= req.packet_end;
        end
    end

`ifndef SYNTHESIS
    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= CW'(DIGITS))
        else $error("cursor beyond last digit");

    a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg == '0 |-> col_reg == '0)
        else $error("row column out of step with cursor");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg <= RW'(ROW_LENGTH - 1))
        else $error("scan column beyond row length");

    a_setup_ends_skip: assert property (@(posedge clk) disable iff (!rst_n)
        step && cmd_reg == CMD_SETUP |=> !skip_reg)
        else $error("setup request left packet skip pending");
`endif

endmodule

### rtl/tsd_store.sv
// tsd_store: digit image memory, one write and two registered read ports,
// per-digit valid bits so a never-written digit reads blank. Uses tsd_pkg.
`timescale 1ns / 1ps

module tsd_store #(
    parameter int DIGITS = tsd_pkg::DIGITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [$clog2(DIGITS)-1:0]     addr_a,
    input  logic [$clog2(DIGITS)-1:0]     addr_b,
    input  logic                          we,
    input  logic [$clog2(DIGITS)-1:0]     waddr,
    input  logic [tsd_pkg::BYTE_W-1:0]    wdata,
    output logic [tsd_pkg::BYTE_W-1:0]    rd_a,
    output logic [tsd_pkg::BYTE_W-1:0]    rd_b
);
    import tsd_pkg::*;

    logic [BYTE_W-1:0] mem [DIGITS];
    logic [DIGITS-1:0] valid_reg;
    logic [BYTE_W-1:0] rd_a_reg;
    logic [BYTE_W-1:0] rd_b_reg;

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (we)
            valid_reg[waddr] <= 1'b1;
    end

    // a write in the same cycle is passed straight to the reader
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            priority if (we && waddr == addr_a)
                rd_a_reg <= wdata;
            else if (valid_reg[addr_a])
                rd_a_reg <= mem[addr_a];
            else
                rd_a_reg <= '0;

            priority if (we && waddr == addr_b)
                rd_b_reg <= wdata;
            else if (valid_reg[addr_b])
                rd_b_reg <= mem[addr_b];
            else
                rd_b_reg <= '0;
        end
    end

endmodule

### rtl/tsd_result.sv
// tsd_result: second stage (period merge, store write-back) and the result
// register. Depends on tsd_pkg and tsd_rsp_if.
`timescale 1ns / 1ps

module tsd_result #(
    parameter int DIGITS = tsd_pkg::DIGITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s1_vld,
    input  tsd_pkg::op_t                        op,
    input  logic [$clog2(DIGITS)-1:0]           addr_a,
    input  logic [tsd_pkg::CURSOR_OUT_W-1:0]    cursor_now,
    input  logic [tsd_pkg::COLUMN_OUT_W-1:0]    scan_col,
    input  logic [tsd_pkg::BYTE_W-1:0]          rd_a,
    input  logic [tsd_pkg::BYTE_W-1:0]          rd_b,
    input  logic [tsd_pkg::BYTE_W-1:0]          point_mask,
    output logic                                s2_adv,
    output logic                                we,
    output logic [$clog2(DIGITS)-1:0]           waddr,
    output logic [tsd_pkg::BYTE_W-1:0]          wdata,
    tsd_rsp_if.source                           rsp
);
    import tsd_pkg::*;

    localparam int AW = $clog2(DIGITS);

    logic                    s2_vld_reg;
    op_t                     op_s2_reg;
    logic [AW-1:0]           addr_s2_reg;
    logic [CURSOR_OUT_W-1:0] cursor_s2_reg;
    logic [COLUMN_OUT_W-1:0] col_s2_reg;

    logic                    out_vld_reg;
    logic                    wrote_reg;
    logic [INDEX_OUT_W-1:0]  index_reg;
    logic [BYTE_W-1:0]       pattern_reg;
    logic [CURSOR_OUT_W-1:0] cursor_reg;
    logic [COLUMN_OUT_W-1:0] column_reg;
    logic [BYTE_W-1:0]       upper_reg;
    logic [BYTE_W-1:0]       lower_reg;

    logic out_free;
    logic wrote;
    logic is_scan;

    assign out_free = !out_vld_reg || rsp.ready;
    assign s2_adv   = !s2_vld_reg || out_free;
    assign wrote    = op_s2_reg.kind == OP_WRITE || op_s2_reg.kind == OP_POINT;
    assign is_scan  = op_s2_reg.kind == OP_SCAN;
    assign wdata    = (op_s2_reg.kind == OP_POINT) ? (rd_a | point_mask) : op_s2_reg.pattern;
    assign waddr    = addr_s2_reg;
    assign we       = s2_vld_reg && out_free && wrote;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s2_adv)
                s2_vld_reg <= s1_vld;
            if (out_free)
                out_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv && s1_vld)
        begin
            op_s2_reg     <= op;
            addr_s2_reg   <= addr_a;
            cursor_s2_reg <= cursor_now;
            col_s2_reg    <= scan_col;
        end
        if (out_free && s2_vld_reg)
        begin
            wrote_reg   <= wrote;
            index_reg   <= wrote ? INDEX_OUT_W'(addr_s2_reg) : '0;
            pattern_reg <= wrote ? wdata : '0;
            cursor_reg  <= cursor_s2_reg;
            column_reg  <= col_s2_reg;
            upper_reg   <= (is_scan && op_s2_reg.hi_ok) ? rd_b : '0;
            lower_reg   <= (is_scan && op_s2_reg.lo_ok) ? rd_a : '0;
        end
    end

    assign rsp.valid             = out_vld_reg;
    assign rsp.wrote_digit       = wrote_reg;
    assign rsp.digit_index       = index_reg;
    assign rsp.digit_pattern     = pattern_reg;
    assign rsp.cursor_now        = cursor_reg;
    assign rsp.scan_column       = column_reg;
    assign rsp.upper_row_pattern = upper_reg;
    assign rsp.lower_row_pattern = lower_reg;

endmodule

### rtl/text_to_seven_segment_display_core.sv
// text_to_seven_segment_display_core: top level, configuration registers and
// the decode / store / result stages. Depends on tsd_pkg, tsd_channels and
// tsd_ctrl, tsd_store, tsd_result.
//
//   port    direction  handshake         carries
//   req     sink       valid / ready     cmd, data_byte, packet_end
//   rsp     source     valid / ready     wrote_digit ... lower_row_pattern
//   cfg     write      cfg_we            cfg_index, cfg_data
//
// one item per cycle while rsp is ready; each item passes the input register, then
// the store read register, then the result register, before its result is valid
// reset clears cursor, scan column, skip flag and the digit valid bits at once,
// so the display reads blank with no clearing pass
// a stalled result holds; empty stages behind it still take new items
`timescale 1ns / 1ps

module text_to_seven_segment_display_core #(
    parameter int DIGITS     = tsd_pkg::DIGITS_DEFAULT,
    parameter int ROW_LENGTH = tsd_pkg::ROW_LENGTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    tsd_req_if.sink                           req,
    tsd_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [tsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tsd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tsd_pkg::*;

    localparam int AW = $clog2(DIGITS);

    logic [BYTE_W-1:0]       point_mask_reg;
    logic [BYTE_W-1:0]       dash_pattern_reg;

    logic                    s1_vld;
    logic                    s2_adv;
    op_t                     op;
    logic [AW-1:0]           addr_a;
    logic [AW-1:0]           addr_b;
    logic [CURSOR_OUT_W-1:0] cursor_now;
    logic [COLUMN_OUT_W-1:0] scan_col;
    logic [BYTE_W-1:0]       rd_a;
    logic [BYTE_W-1:0]       rd_b;
    logic                    we;
    logic [AW-1:0]           waddr;
    logic [BYTE_W-1:0]       wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_mask_reg   <= POINT_MASK_RESET;
            dash_pattern_reg <= DASH_PATTERN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POINT_MASK:   point_mask_reg   <= BYTE_W'(cfg_data);
                REG_DASH_PATTERN: dash_pattern_reg <= BYTE_W'(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    tsd_ctrl #(
        .DIGITS     (DIGITS),
        .ROW_LENGTH (ROW_LENGTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .s2_adv       (s2_adv),
        .dash_pattern (dash_pattern_reg),
        .s1_vld       (s1_vld),
        .op           (op),
        .addr_a       (addr_a),
        .addr_b       (addr_b),
        .cursor_now   (cursor_now),
        .scan_col     (scan_col)
    );

    tsd_store #(
        .DIGITS (DIGITS)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (s2_adv),
        .addr_a (addr_a),
        .addr_b (addr_b),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .rd_a   (rd_a),
        .rd_b   (rd_b)
    );

    tsd_result #(
        .DIGITS (DIGITS)
    ) u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_vld     (s1_vld),
        .op         (op),
        .addr_a     (addr_a),
        .cursor_now (cursor_now),
        .scan_col   (scan_col),
        .rd_a       (rd_a),
        .rd_b       (rd_b),
        .point_mask (point_mask_reg),
        .s2_adv     (s2_adv),
        .we         (we),
        .waddr      (waddr),
        .wdata      (wdata),
        .rsp        (rsp)
    );

endmodule
